FILE: design/bgcb_pkg.sv
// Shared types, constants and functions for the blob grid colour binner.
package bgcb_pkg;

    localparam int MAX_BLOBS = 64;
    localparam int ADDR_W    = $clog2(MAX_BLOBS);
    localparam int CNT_W     = $clog2(MAX_BLOBS + 1);
    localparam int POS_W     = 9;
    localparam int X_W       = 9;
    localparam int Y_W       = 8;
    localparam int SIG_W     = 3;
    localparam int COLOR_W   = 3;
    localparam int ENTRY_W   = X_W + Y_W + SIG_W;
    localparam int GRID_N    = 9;
    localparam int GRID_IW   = 4;

    localparam logic [COLOR_W-1:0] COLOR_UNKNOWN = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_WHITE   = 3'd6;
    localparam logic [1:0]         BIN_LAST      = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_BINX,
        S_BINY,
        S_EMIT
    } t_state;

    // operands of the shared binning unit
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] lo;
        logic [POS_W-1:0] hi;
    } t_bin_req;

    function automatic logic [COLOR_W-1:0] color_of(input logic [SIG_W-1:0] sig);
        logic [COLOR_W-1:0] c;
        c = COLOR_WHITE;
        if (sig >= 3'd1 && sig <= 3'd6) begin
            c = sig;
        end
        return c;
    endfunction

endpackage

FILE: design/blob_grid_color_binner_unit.sv
// Top level of the blob grid colour binner: blob store, sequencer and cell output.
// A blob without the last mark is taken and the unit stays ready for further blobs.
// A last-marked blob starts a scan of every stored blob in turn (store read, x bin,
// y bin through one shared binning unit), then nine output words.
// Throughput: one blob per cycle while collecting; the store read port and the shared
// binning unit set the scan length. Reset (synchronous, active low) clears the box,
// count, grid and sequencer; the blob store itself is not cleared.
module blob_grid_color_binner_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [bgcb_pkg::X_W-1:0]        i_pos_x,
    input  logic [bgcb_pkg::Y_W-1:0]        i_pos_y,
    input  logic [bgcb_pkg::SIG_W-1:0]      i_color_signature,
    input  logic                            i_last_block,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [bgcb_pkg::COLOR_W-1:0]    o_cell_color,
    output logic [1:0]                      o_cell_row,
    output logic [1:0]                      o_cell_col,
    output logic                            o_last_cell
);
    import bgcb_pkg::*;

    t_state r_state, n_state;

    // bounding box of the stored blobs
    logic [X_W-1:0]     r_min_x, r_max_x;
    logic [Y_W-1:0]     r_min_y, r_max_y;
    logic [CNT_W-1:0]   r_count;

    // blob store, written while collecting, read at each blob's index during the scan
    logic [ENTRY_W-1:0] r_store [MAX_BLOBS];
    logic [ENTRY_W-1:0] r_rd_data;
    logic [CNT_W-1:0]   r_idx;

    logic [COLOR_W-1:0] r_grid [GRID_N];
    logic [1:0]         r_col_bin;

    // output cell pointer
    logic [1:0]         r_erow, r_ecol;
    logic [GRID_IW-1:0] r_eidx;

    logic               in_acc, out_acc, can_store;
    logic               last_entry;
    t_bin_req           bin_req;
    logic [1:0]         bin;
    logic [GRID_IW-1:0] wr_cell;
    logic [X_W-1:0]     ent_x;
    logic [Y_W-1:0]     ent_y;
    logic [SIG_W-1:0]   ent_sig;

    assign in_acc     = i_valid & o_ready;
    assign out_acc    = o_valid & i_ready;
    assign can_store  = (r_count < CNT_W'(MAX_BLOBS));
    assign last_entry = ((r_idx + 1'b1) >= r_count);

    assign ent_x   = r_rd_data[X_W-1:0];
    assign ent_y   = r_rd_data[X_W+Y_W-1:X_W];
    assign ent_sig = r_rd_data[ENTRY_W-1:X_W+Y_W];

    // one binning unit, shared between the x and y steps
    always_comb begin
        if (r_state == S_BINY) begin
            bin_req.pos = {1'b0, ent_y};
            bin_req.lo  = {1'b0, r_min_y};
            bin_req.hi  = {1'b0, r_max_y};
        end else begin
            bin_req.pos = ent_x;
            bin_req.lo  = r_min_x;
            bin_req.hi  = r_max_x;
        end
    end

    bgcb_bin_unit u_bin (
        .i_req (bin_req),
        .o_bin (bin)
    );

    // row * 3 + col
    assign wr_cell = {1'b0, bin, 1'b0} + {2'b00, bin} + {2'b00, r_col_bin};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc && i_last_block) n_state = S_READ;
            S_READ: n_state = S_BINX;
            S_BINX: n_state = S_BINY;
            S_BINY: n_state = last_entry ? S_EMIT : S_READ;
            S_EMIT: if (out_acc && r_eidx == GRID_IW'(GRID_N - 1)) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: o_ready = 1'b1;
            S_EMIT: o_valid = 1'b1;
            default: ;
        endcase
    end

    assign o_cell_color = r_grid[r_eidx];
    assign o_cell_row   = r_erow;
    assign o_cell_col   = r_ecol;
    assign o_last_cell  = (r_eidx == GRID_IW'(GRID_N - 1));

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (in_acc && can_store) begin
            r_store[r_count[ADDR_W-1:0]] <= {i_color_signature, i_pos_y, i_pos_x};
        end
        r_rd_data <= r_store[r_idx[ADDR_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_BINX) begin
            r_col_bin <= bin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_min_x <= '1;
            r_max_x <= '0;
            r_min_y <= '1;
            r_max_y <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_erow  <= '0;
            r_ecol  <= '0;
            r_eidx  <= '0;
            for (int i = 0; i < GRID_N; i++) r_grid[i] <= COLOR_UNKNOWN;
        end else begin
            r_state <= n_state;
            if (in_acc && can_store) begin
                r_count <= r_count + 1'b1;
                if (i_pos_x < r_min_x) r_min_x <= i_pos_x;
                if (i_pos_x > r_max_x) r_max_x <= i_pos_x;
                if (i_pos_y < r_min_y) r_min_y <= i_pos_y;
                if (i_pos_y > r_max_y) r_max_y <= i_pos_y;
            end
            if (r_state == S_BINY) begin
                r_grid[wr_cell] <= color_of(ent_sig);   // later blob wins
                r_idx           <= last_entry ? '0 : r_idx + 1'b1;
            end
            if (out_acc) begin
                if (o_last_cell) begin
                    // frame done: back to the empty frame
                    r_erow  <= '0;
                    r_ecol  <= '0;
                    r_eidx  <= '0;
                    r_min_x <= '1;
                    r_max_x <= '0;
                    r_min_y <= '1;
                    r_max_y <= '0;
                    r_count <= '0;
                    for (int i = 0; i < GRID_N; i++) r_grid[i] <= COLOR_UNKNOWN;
                end else begin
                    r_eidx <= r_eidx + 1'b1;
                    if (r_ecol == BIN_LAST) begin
                        r_ecol <= '0;
                        r_erow <= r_erow + 1'b1;
                    end else begin
                        r_ecol <= r_ecol + 1'b1;
                    end
                end
            end
        end
    end

endmodule

FILE: design/bgcb_bin_unit.sv
// Shared binning unit: places a coordinate into one of three bins of a span.
module bgcb_bin_unit (
    input  bgcb_pkg::t_bin_req i_req,
    output logic [1:0]         o_bin
);
    import bgcb_pkg::*;

    logic [POS_W-1:0] span;
    logic [POS_W-1:0] off;
    logic [POS_W+1:0] off3;
    logic [POS_W:0]   span2;

    always_comb begin
        span  = i_req.hi - i_req.lo;
        off   = (i_req.pos >= i_req.lo) ? (i_req.pos - i_req.lo) : '0;
        off3  = {2'b00, off} + {1'b0, off, 1'b0};
        span2 = {span, 1'b0};
        if (i_req.hi <= i_req.lo) begin
            o_bin = 2'd0;                       // flat axis
        end else if (off3 >= {1'b0, span2}) begin
            o_bin = 2'd2;
        end else if (off3 >= {2'b00, span}) begin
            o_bin = 2'd1;
        end else begin
            o_bin = 2'd0;
        end
    end

endmodule
